@@ hw/rtl/sm4_pkg.sv @@
// SM4 package: S-box, round function, payload types.
package sm4_pkg;

	localparam int RK_AW = 5;

	typedef struct packed {
		logic        dec;
		logic [63:0] blk_lo;
		logic [63:0] blk_hi;
	} sm4_in_t;

	typedef logic [7:0] sbox_arr_t [256];

	localparam sbox_arr_t SBOX = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] tau_l(input logic [31:0] a);
		logic [31:0] b;
		b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
		tau_l = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

endpackage

@@ hw/rtl/sm4_round.sv @@
// One SM4 round as a pipeline stage with its own copies of the forward and reverse round keys.
module sm4_round #(
	parameter int unsigned RNUM = 0,
	parameter int unsigned NR = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      key_we,
	input  logic [sm4_pkg::RK_AW-1:0] key_idx,
	input  logic [31:0]               key_wd,
	input  logic                      vld_in,
	input  logic                      dec_in,
	input  logic [127:0]              w_in,
	output logic                      key_we_s1,
	output logic [sm4_pkg::RK_AW-1:0] key_idx_s1,
	output logic [31:0]               key_wd_s1,
	output logic                      vld_s1,
	output logic                      dec_s1,
	output logic [127:0]              w_s1
);
	import sm4_pkg::*;

	localparam logic [RK_AW-1:0] FWD = RK_AW'(RNUM);
	localparam logic [RK_AW-1:0] REV = RK_AW'(NR - 1 - RNUM);

	logic [31:0] kf_q, kr_q, rk, t;

	// each stage keeps the two key words it can ever need; a key load updates
	// this stage when it passes, so blocks ahead of it keep the old word
	always_ff @(posedge clk) begin
		if (en && key_we && key_idx == FWD) kf_q <= key_wd;
		if (en && key_we && key_idx == REV) kr_q <= key_wd;
	end

	assign rk = dec_in ? kr_q : kf_q;
	assign t  = w_in[127:96] ^ tau_l(w_in[95:64] ^ w_in[63:32] ^ w_in[31:0] ^ rk);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			key_we_s1 <= 1'b0;
		end else if (en) begin
			vld_s1    <= vld_in;
			key_we_s1 <= key_we;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1     <= dec_in;
			w_s1       <= {w_in[95:0], t};
			key_idx_s1 <= key_idx;
			key_wd_s1  <= key_wd;
		end
	end
endmodule

@@ hw/rtl/sm4_block_cipher_top.sv @@
// SM4 cipher top: key load, 32-stage round pipeline, output taken from the last stage's registers.
//  channel | dir | tdata (low bit up)                          | tuser
//  s_axis  | in  | key_index, key_word, block_high, block_low, decrypt (pad) | kind
//  m_axis  | out | result_high, result_low                     | -
// One round per stage; one request per cycle while m_axis does not stall.
// Key loads travel down the pipeline, updating the stages that use that key word; no result.
// Reset clears the valid and key-write bits only; key words hold garbage until loaded.
// A stall on m_axis freezes the whole pipeline; nothing is dropped.
module sm4_block_cipher_top #(
	parameter int unsigned ROUND_COUNT = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [167:0] s_axis_tdata,  // key_index, key_word, block_high, block_low, decrypt
	input  logic         s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // result_high, result_low
);
	import sm4_pkg::*;

	logic               en, acc, key_we;
	logic [ROUND_COUNT:0] vld;
	logic [ROUND_COUNT:0] dec;
	logic [ROUND_COUNT:0] kwe;
	logic [RK_AW-1:0]   kidx [ROUND_COUNT+1];
	logic [31:0]        kwd [ROUND_COUNT+1];
	logic [127:0]       w [ROUND_COUNT+1];
	logic [127:0]       res;

	assign en  = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign key_we = acc && !s_axis_tuser;

	assign vld[0]  = acc && s_axis_tuser;
	assign dec[0]  = s_axis_tdata[165];
	assign w[0]    = {s_axis_tdata[100:37], s_axis_tdata[164:101]};
	assign kwe[0]  = key_we;
	assign kidx[0] = s_axis_tdata[4:0];
	assign kwd[0]  = s_axis_tdata[36:5];

	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_rnd
		sm4_round #(.RNUM(i), .NR(ROUND_COUNT)) u_rnd (
			.clk(clk), .arst_n(arst_n), .en(en), .key_we(kwe[i]),
			.key_idx(kidx[i]), .key_wd(kwd[i]),
			.vld_in(vld[i]), .dec_in(dec[i]), .w_in(w[i]),
			.key_we_s1(kwe[i+1]), .key_idx_s1(kidx[i+1]), .key_wd_s1(kwd[i+1]),
			.vld_s1(vld[i+1]), .dec_s1(dec[i+1]), .w_s1(w[i+1])
		);
	end

	assign res = w[ROUND_COUNT];
	assign m_axis_tvalid = vld[ROUND_COUNT];
	// w holds X0..X3 high to low; output is X1,X0 | X3,X2 high to low
	assign m_axis_tdata = {res[95:64], res[127:96], res[31:0], res[63:32]};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready mismatch");
	a_key_noout: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |=> !vld[1])
		else $error("key load entered pipeline");
	a_key_drain: assert property (@(posedge clk) disable iff (!arst_n)
		kwe[ROUND_COUNT] |-> !m_axis_tvalid)
		else $error("key load slot carried a result");
endmodule

@@ verif/tb_sm4_block_cipher_top.sv @@
// Testbench for the SM4 block cipher top: key loads, block requests, scoreboard check.
`timescale 1ns / 1ps
module tb_sm4_block_cipher_top;
	localparam int ROUNDS = 32;
	localparam logic KIND_KEY = 1'b0;
	localparam logic KIND_BLOCK = 1'b1;

	typedef struct {
		logic        kind;
		logic [4:0]  idx;
		logic [31:0] kw;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        dec;
		logic        has_exp;
		logic [63:0] exp_hi;
		logic [63:0] exp_lo;
	} req_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [167:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;

	sm4_block_cipher_top dut (.*);

	always #2 clk = ~clk;

	logic [31:0]  key_store [ROUNDS];
	logic [127:0] expected_blocks [$];
	int errors = 0, blocks_sent = 0, keys_sent = 0, blocks_seen = 0;
	bit hold_done = 0;
	int n_dir;
	req_t dir_tab [0:15];

	function automatic logic [31:0] rol32(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] round_t(logic [31:0] a);
		logic [31:0] b;
		b = {sm4_pkg::SBOX[a[31:24]], sm4_pkg::SBOX[a[23:16]],
			sm4_pkg::SBOX[a[15:8]], sm4_pkg::SBOX[a[7:0]]};
		return b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
	endfunction

	function automatic logic [127:0] cipher_block(logic [63:0] hi, logic [63:0] lo, logic dec);
		logic [31:0] x0, x1, x2, x3, t;
		{x0, x1} = hi;
		{x2, x3} = lo;
		for (int r = 0; r < ROUNDS; r++) begin
			t = x0 ^ round_t(x1 ^ x2 ^ x3 ^ key_store[dec ? ROUNDS - 1 - r : r]);
			x0 = x1; x1 = x2; x2 = x3; x3 = t;
		end
		return {x3, x2, x1, x0};
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(req_t r);
		int g;
		g = gap_len() * (($urandom_range(0, 3) == 0) ? 1 : 0);
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.kind;
		s_axis_tdata <= {2'b0, r.dec, r.lo, r.hi, r.kw, r.idx};
		do @(posedge clk); while (!s_axis_tready);
		if (r.kind == KIND_KEY) begin
			key_store[r.idx] = r.kw;
			keys_sent++;
		end else begin
			if (r.has_exp)
				expected_blocks.push_back({r.exp_hi, r.exp_lo});
			else
				expected_blocks.push_back(cipher_block(r.hi, r.lo, r.dec));
			blocks_sent++;
		end
		@(negedge clk);
	endtask

	function automatic req_t key_req(logic [4:0] i, logic [31:0] w);
		req_t r;
		r = '{default: '0};
		r.kind = KIND_KEY; r.idx = i; r.kw = w;
		r.hi = {$urandom, $urandom}; r.lo = {$urandom, $urandom}; r.dec = 1'($urandom);
		return r;
	endfunction

	function automatic req_t blk_req(logic [63:0] hi, logic [63:0] lo, logic dec);
		req_t r;
		r = '{default: '0};
		r.kind = KIND_BLOCK; r.hi = hi; r.lo = lo; r.dec = dec;
		r.idx = 5'($urandom); r.kw = $urandom;
		return r;
	endfunction

	// standard key schedule for the published test key, used for a known-answer check
	task automatic load_standard_keys();
		logic [31:0] mk [4], k [36], fk [4], ck;
		fk = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};
		mk = '{32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210};
		for (int i = 0; i < 4; i++) k[i] = mk[i] ^ fk[i];
		for (int i = 0; i < 32; i++) begin
			logic [31:0] a, b;
			for (int j = 0; j < 4; j++)
				ck[31 - 8*j -: 8] = 8'((4*i + j) * 7);
			a = k[i+1] ^ k[i+2] ^ k[i+3] ^ ck;
			b = {sm4_pkg::SBOX[a[31:24]], sm4_pkg::SBOX[a[23:16]],
				sm4_pkg::SBOX[a[15:8]], sm4_pkg::SBOX[a[7:0]]};
			k[i+4] = k[i] ^ b ^ rol32(b, 13) ^ rol32(b, 23);
			send(key_req(i[4:0], k[i+4]));
		end
	endtask

	initial begin
		req_t r;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		load_standard_keys();
		// known answer: plaintext equals the key
		r = blk_req(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
		r.has_exp = 1; r.exp_hi = 64'h681edf34d206965e; r.exp_lo = 64'h86b3e94f536e4246;
		dir_tab[0] = r;
		r = blk_req(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b1);
		r.has_exp = 1; r.exp_hi = 64'h0123456789abcdef; r.exp_lo = 64'hfedcba9876543210;
		dir_tab[1] = r;
		dir_tab[2] = blk_req('0, '0, 1'b0);
		dir_tab[3] = blk_req('1, '1, 1'b0);
		dir_tab[4] = blk_req('0, '1, 1'b1);
		dir_tab[5] = blk_req('1, '0, 1'b1);
		dir_tab[6] = key_req(5'd0, 32'h0);
		dir_tab[7] = key_req(5'd31, 32'hffffffff);
		dir_tab[8] = blk_req('1, '1, 1'b0);
		dir_tab[9] = blk_req('0, '0, 1'b1);
		dir_tab[10] = key_req(5'd16, 32'h80000001);
		dir_tab[11] = blk_req(64'h8000000000000001, 64'h0000000180000000, 1'b0);
		n_dir = 12;
		for (int i = 0; i < n_dir; i++) send(dir_tab[i]);
		for (int i = 0; i < 2000; i++) begin
			if ($urandom_range(0, 9) == 0)
				send(key_req(5'($urandom), $urandom));
			else
				send(blk_req({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom)));
		end
		s_axis_tvalid <= 1'b0;
		while (expected_blocks.size() != 0) @(posedge clk);
		repeat (ROUNDS + 8) @(posedge clk);
		$display("Covered %0d key loads and %0d block requests (encrypt and decrypt).",
			keys_sent, blocks_sent);
		$display("Checked %0d result blocks, incl. a standard known-answer pair.", blocks_seen);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off so the pipeline backs up
	initial begin
		int n;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && blocks_sent > 300) begin
				m_axis_tready <= 1'b0;
				hold_done = 1;
				for (int c = 0; c < 200; c++) @(negedge clk);
			end
			n = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else
				m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [127:0] e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			blocks_seen++;
			if (expected_blocks.size() == 0) begin
				$error("result with no request pending: %h", m_axis_tdata);
				errors++;
			end else begin
				e = expected_blocks.pop_front();
				if (m_axis_tdata[63:0] !== e[127:64]) begin
					$error("result_high expected %h got %h", e[127:64], m_axis_tdata[63:0]);
					errors++;
				end
				if (m_axis_tdata[127:64] !== e[63:0]) begin
					$error("result_low expected %h got %h", e[63:0], m_axis_tdata[127:64]);
					errors++;
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
